FILE: sv/sltok_pkg.sv
// Shared types, character codes and helpers for the script line and word tokenizer.
`timescale 1ns / 1ps

package sltok_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_NUL       = 8'h00;

   localparam int START_W = 12;
   localparam int LENGTH_W = 13;
   localparam int COUNT_W = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic KIND_WORD = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   // Result queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W = 2;
   localparam int FILL_W = 3;

   typedef enum logic [2:0] {
      CLS_EOL,
      CLS_BACKSLASH,
      CLS_QUOTE,
      CLS_SPACE,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic                token_kind;
      logic [START_W-1:0]  start_pos;
      logic [LENGTH_W-1:0] token_length;
      logic [COUNT_W-1:0]  line_word_count;
      logic                overflow_seen;
      logic                last_in_run;
   } result_type;

   // Zero, one or two results written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == COUNT_MAX) ? value : value + 1'b1;
      return result;
   endfunction

endpackage

FILE: sv/sltok_core.sv
// Tokenizer state and per-byte classification, emitting up to two results per item.
`timescale 1ns / 1ps

module sltok_core import sltok_pkg::*; #(
   parameter int BUFFER_SIZE = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       end_of_buffer,
   output push_type   push
);

   localparam int PW = $clog2(BUFFER_SIZE + 1);
   localparam logic [PW-1:0] POS_LIMIT = PW'(BUFFER_SIZE);

   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      line_begin_ff, line_begin_in;
   logic [PW-1:0]      word_begin_ff, word_begin_in;
   logic               escape_ff, escape_in;
   logic               quotes_ff, quotes_in;
   logic [COUNT_W-1:0] words_ff, words_in;
   logic               overflow_ff, overflow_in;

   char_class_type     char_class;
   logic               ovf_now;
   logic               flag;

   // State after the byte itself, before any buffer-end close
   logic [PW-1:0]      pos_a, line_begin_a, word_begin_a;
   logic               escape_a, quotes_a;
   logic [COUNT_W-1:0] words_a, words_line_a, words_line_b;

   result_type         cand [4];
   logic [3:0]         cand_vld;
   logic [1:0]         n_push;
   result_type         res0, res1;

   function automatic result_type make_result(input logic kind, input logic [PW-1:0] start,
                                              input logic [PW-1:0] len,
                                              input logic [COUNT_W-1:0] count,
                                              input logic ovf);
      result_type r;
      r.token_kind      = kind;
      r.start_pos       = START_W'(start);
      r.token_length    = LENGTH_W'(len);
      r.line_word_count = count;
      r.overflow_seen   = ovf;
      r.last_in_run     = 1'b0;
      return r;
   endfunction

   always_comb begin
      unique case (data_byte) inside
         CH_CR, CH_LF, CH_NUL: char_class = CLS_EOL;
         CH_BACKSLASH:         char_class = CLS_BACKSLASH;
         CH_QUOTE:             char_class = CLS_QUOTE;
         CH_SPACE:             char_class = CLS_SPACE;
         default:              char_class = CLS_OTHER;
      endcase
   end

   assign ovf_now = (pos_ff >= POS_LIMIT);
   assign flag    = overflow_ff | ovf_now;

   // Handling of the byte itself: word or line ends at the current position
   always_comb begin
      pos_a        = pos_ff;
      line_begin_a = line_begin_ff;
      word_begin_a = word_begin_ff;
      escape_a     = escape_ff;
      quotes_a     = quotes_ff;
      words_a      = words_ff;
      words_line_a = words_ff;
      cand[0]      = make_result(KIND_WORD, word_begin_ff, pos_ff - word_begin_ff, '0, flag);
      cand[1]      = make_result(KIND_LINE, line_begin_ff, pos_ff - line_begin_ff,
                                 words_line_a, flag);
      cand_vld[1:0] = 2'b00;
      if (!ovf_now) begin
         pos_a = pos_ff + 1'b1;
         case (char_class)
            CLS_EOL: begin
               if (pos_ff > line_begin_ff) begin
                  if (pos_ff > word_begin_ff) begin
                     cand_vld[0]  = 1'b1;
                     words_line_a = count_inc(words_ff);
                  end
                  cand_vld[1] = 1'b1;
                  cand[1]     = make_result(KIND_LINE, line_begin_ff, pos_ff - line_begin_ff,
                                            words_line_a, flag);
               end
               line_begin_a = pos_a;
               word_begin_a = pos_a;
               escape_a     = 1'b0;
               quotes_a     = 1'b0;
               words_a      = '0;
            end
            CLS_BACKSLASH: begin
               if (escape_ff) escape_a = 1'b0;
               else           escape_a = 1'b1;
            end
            CLS_QUOTE: begin
               if (escape_ff) escape_a = 1'b0;
               else           quotes_a = ~quotes_ff;
            end
            CLS_SPACE: begin
               if (escape_ff) begin
                  escape_a = 1'b0;
               end else if (!quotes_ff) begin
                  if (pos_ff > word_begin_ff) begin
                     cand_vld[0] = 1'b1;
                     words_a     = count_inc(words_ff);
                  end
                  word_begin_a = pos_a;
               end
            end
            default: escape_a = 1'b0;
         endcase
      end

      // Buffer end closes the open line just after the last byte
      cand_vld[3:2] = 2'b00;
      words_line_b  = words_a;
      if (end_of_buffer && (pos_a > line_begin_a)) begin
         if (pos_a > word_begin_a) begin
            cand_vld[2]  = 1'b1;
            words_line_b = count_inc(words_a);
         end
         cand_vld[3] = 1'b1;
      end
      cand[2] = make_result(KIND_WORD, word_begin_a, pos_a - word_begin_a, '0, flag);
      cand[3] = make_result(KIND_LINE, line_begin_a, pos_a - line_begin_a, words_line_b, flag);
   end

   // At most two candidates are ever valid; pack them in order
   always_comb begin
      n_push = 2'd0;
      res0   = cand[0];
      res1   = cand[1];
      for (int i = 0; i < 4; i++) begin
         if (cand_vld[i]) begin
            if (n_push == 2'd0) res0 = cand[i];
            else                res1 = cand[i];
            n_push = n_push + 2'd1;
         end
      end
      if (n_push == 2'd2) res1.last_in_run = 1'b1;
      else                res0.last_in_run = 1'b1;
   end

   assign push.count  = take ? n_push : 2'd0;
   assign push.first  = res0;
   assign push.second = res1;

   always_comb begin
      if (end_of_buffer) begin
         pos_in        = '0;
         line_begin_in = '0;
         word_begin_in = '0;
         escape_in     = 1'b0;
         quotes_in     = 1'b0;
         words_in      = '0;
         overflow_in   = 1'b0;
      end else begin
         pos_in        = pos_a;
         line_begin_in = line_begin_a;
         word_begin_in = word_begin_a;
         escape_in     = escape_a;
         quotes_in     = quotes_a;
         words_in      = words_a;
         overflow_in   = flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         line_begin_ff <= '0;
         word_begin_ff <= '0;
         escape_ff     <= 1'b0;
         quotes_ff     <= 1'b0;
         words_ff      <= '0;
         overflow_ff   <= 1'b0;
      end else if (take) begin
         pos_ff        <= pos_in;
         line_begin_ff <= line_begin_in;
         word_begin_ff <= word_begin_in;
         escape_ff     <= escape_in;
         quotes_ff     <= quotes_in;
         words_ff      <= words_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

FILE: sv/sltok_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one.
`timescale 1ns / 1ps

module sltok_fifo import sltok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   result_type          entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                pop;

   assign out_valid = (fill_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   // Room for a worst-case item of two results
   assign space     = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign fill_in   = fill_ff + FILL_W'(push.count) - FILL_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: sv/script_line_word_tokenizer.sv
// Top level of the script line and word tokenizer: byte stream in, word and line items out.
//
//   channel  | direction | tdata                                     | tlast         | tuser
//   req_     | in        | [7:0] data_byte                           | end_of_buffer | -
//   rsp_     | out       | [11:0] start_pos, [24:12] token_length,   | last_in_run   | token_kind
//            |           | [36:25] line_word_count, [37] overflow    |               |
//
// One byte is taken per cycle while req_tready is high; its results are written to a four-entry
// queue in the same cycle and reach rsp_ from the next cycle, one per cycle while rsp_ is ready.
// req_tready is high while the queue holds two results or fewer, so a byte that yields two
// results limits the rate to the result port's one item per cycle.
// Synchronous active-high reset clears the tokenizer state and empties the queue.

`timescale 1ns / 1ps

module script_line_word_tokenizer import sltok_pkg::*; #(
   parameter int BUFFER_SIZE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // start_pos, token_length, line_word_count, overflow_seen
   output logic        rsp_tlast,
   output logic        rsp_tuser    // token_kind
);

   push_type   push;
   result_type out_item;
   logic       space;
   logic       take;

   assign req_tready = space;
   assign take       = req_tvalid & space;

   sltok_core #(
      .BUFFER_SIZE(BUFFER_SIZE)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_tdata),
      .end_of_buffer(req_tlast),
      .push         (push)
   );

   sltok_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space    (space),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_item (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.overflow_seen, out_item.line_word_count,
                       out_item.token_length, out_item.start_pos};
   assign rsp_tlast = out_item.last_in_run;
   assign rsp_tuser = out_item.token_kind;

endmodule

FILE: tb/sv/script_line_word_tokenizer_tb.sv
// Self-checking testbench for the script line and word tokenizer.
`timescale 1ns / 1ps

module script_line_word_tokenizer_tb;
   import sltok_pkg::*;

   localparam int BUF_BYTES = 4096;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int PREDICTED = -1;
   localparam int SMALL_BYTES = 1900;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tlast = 1'b0; // end_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [11:0] start_pos, [24:12] token_length,
                                  // [36:25] line_word_count, [37] overflow_seen
   logic        rsp_tlast;        // last_in_run
   logic        rsp_tuser;        // token_kind

   script_line_word_tokenizer #(.BUFFER_SIZE(BUF_BYTES)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // scanner state mirrored from the block
   int unsigned scan_pos, line_start, word_start, word_tally;
   bit          escaped, quoted, saturated;
   result_type  step_res [2];
   int          step_n;

   result_type  pending_tokens [$];
   int          mismatches = 0;
   int          bytes_accepted = 0;
   int          results_checked = 0;
   int          lines_checked = 0;
   int          buffers_closed = 0;
   int          overflow_buffers = 0;
   int          cycle_count = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;

   typedef struct {
      logic [7:0] ch;
      logic       eob;
      int         typed;   // results typed in below, or PREDICTED
      result_type first;
      result_type second;
   } directed_row_type;

   // Short directed sequence: quoting, escapes, empty lines and buffer ends.
   directed_row_type directed_rows [25] = '{
      '{"a", 1'b1, 2, result_type'{KIND_WORD, 12'd0, 13'd1, 12'd0, 1'b0, 1'b0},
                      result_type'{KIND_LINE, 12'd0, 13'd1, 12'd1, 1'b0, 1'b1}},
      '{CH_CR, 1'b1, 0, '0, '0},
      '{8'hFF, 1'b0, 0, '0, '0},
      '{CH_NUL, 1'b0, 2, result_type'{KIND_WORD, 12'd0, 13'd1, 12'd0, 1'b0, 1'b0},
                         result_type'{KIND_LINE, 12'd0, 13'd1, 12'd1, 1'b0, 1'b1}},
      '{CH_QUOTE, 1'b0, PREDICTED, '0, '0},
      '{"a", 1'b0, PREDICTED, '0, '0},
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},    // kept: inside quotes
      '{"b", 1'b0, PREDICTED, '0, '0},
      '{CH_QUOTE, 1'b0, PREDICTED, '0, '0},
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},
      '{CH_BACKSLASH, 1'b0, PREDICTED, '0, '0},
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},    // escaped space
      '{CH_BACKSLASH, 1'b0, PREDICTED, '0, '0},
      '{CH_BACKSLASH, 1'b0, PREDICTED, '0, '0},
      '{CH_BACKSLASH, 1'b0, PREDICTED, '0, '0},
      '{CH_QUOTE, 1'b0, PREDICTED, '0, '0},    // escaped quote
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},
      '{CH_LF, 1'b0, PREDICTED, '0, '0},
      '{CH_CR, 1'b0, PREDICTED, '0, '0},       // empty line
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},
      '{CH_LF, 1'b0, PREDICTED, '0, '0},       // line of one space, no words
      '{"z", 1'b0, PREDICTED, '0, '0},
      '{CH_SPACE, 1'b0, PREDICTED, '0, '0},
      '{CH_QUOTE, 1'b1, PREDICTED, '0, '0}     // open quote at buffer end
   };

   function automatic void post_token(logic kind, int unsigned start, int unsigned len,
                                      int unsigned cnt);
      result_type t;
      t.token_kind      = kind;
      t.start_pos       = start[START_W-1:0];
      t.token_length    = len[LENGTH_W-1:0];
      t.line_word_count = cnt[COUNT_W-1:0];
      t.overflow_seen   = saturated;
      t.last_in_run     = 1'b0;
      step_res[step_n]  = t;
      step_n++;
   endfunction

   function automatic void count_word();
      if (word_tally < COUNT_MAX)
         word_tally++;
   endfunction

   function automatic void end_line(int unsigned stop);
      if (stop > line_start) begin
         if (stop > word_start) begin
            post_token(KIND_WORD, word_start, stop - word_start, 0);
            count_word();
         end
         post_token(KIND_LINE, line_start, stop - line_start, word_tally);
      end
      line_start = stop + 1;
      word_start = stop + 1;
      escaped    = 1'b0;
      quoted     = 1'b0;
      word_tally = 0;
   endfunction

   function automatic void clear_scanner();
      scan_pos   = 0;
      line_start = 0;
      word_start = 0;
      word_tally = 0;
      escaped    = 1'b0;
      quoted     = 1'b0;
      saturated  = 1'b0;
   endfunction

   // Works out the results of one accepted byte into step_res / step_n.
   function automatic void tokenize_byte(logic [7:0] ch, logic eob);
      int unsigned p;
      step_n = 0;
      if (scan_pos >= BUF_BYTES) begin
         saturated = 1'b1;
      end else begin
         p = scan_pos;
         if (ch == CH_CR || ch == CH_LF || ch == CH_NUL) begin
            end_line(p);
         end else if (ch == CH_BACKSLASH && !escaped) begin
            escaped = 1'b1;
         end else if (ch == CH_QUOTE && !escaped) begin
            quoted = !quoted;
         end else if (ch == CH_SPACE && !quoted && !escaped) begin
            if (p > word_start) begin
               post_token(KIND_WORD, word_start, p - word_start, 0);
               count_word();
            end
            word_start = p + 1;
         end else if (escaped) begin
            escaped = 1'b0;
         end
         scan_pos = p + 1;
      end
      if (eob) begin
         end_line(scan_pos);
         buffers_closed++;
         if (saturated)
            overflow_buffers++;
         clear_scanner();
      end
      if (step_n > 0)
         step_res[step_n-1].last_in_run = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Mostly text with the characters the scanner cares about, some raw bytes.
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 60) return CH_SPACE;
      if (r < 67) return CH_QUOTE;
      if (r < 74) return CH_BACKSLASH;
      if (r < 79) return CH_CR;
      if (r < 84) return CH_LF;
      if (r < 87) return CH_NUL;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic offer_byte(input logic [7:0] ch, input logic eob,
                             input int typed = PREDICTED,
                             input result_type t0 = '0, input result_type t1 = '0);
      logic took;
      int   gap;
      req_tdata  <= ch;
      req_tlast  <= eob;
      req_tvalid <= 1'b1;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      tokenize_byte(ch, eob);
      if (typed == PREDICTED) begin
         for (int k = 0; k < step_n; k++)
            pending_tokens.push_back(step_res[k]);
      end else begin
         if (typed > 0) pending_tokens.push_back(t0);
         if (typed > 1) pending_tokens.push_back(t1);
      end
      bytes_accepted++;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected result item: tdata %h tuser %b tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_tokens.pop_front();
            check_field("token_kind", want.token_kind, rsp_tuser);
            check_field("start_pos", want.start_pos, rsp_tdata[11:0]);
            check_field("token_length", want.token_length, rsp_tdata[24:12]);
            check_field("line_word_count", want.line_word_count, rsp_tdata[36:25]);
            check_field("overflow_seen", want.overflow_seen, rsp_tdata[37]);
            check_field("tdata padding", 0, rsp_tdata[39:38]);
            check_field("last_in_run", want.last_in_run, rsp_tlast);
            results_checked++;
            if (want.token_kind == KIND_LINE)
               lines_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("script_line_word_tokenizer_tb failed");
         $finish;
      end
   end

   // Receiver: random ready pattern, plus one long hold-off so the queue backs up.
   initial begin : result_sink
      bit held_off;
      int gap;
      held_off = 1'b0;
      repeat (12) @(posedge clock);
      forever begin
         if (!held_off && bytes_accepted >= 300) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if ($urandom_range(0, 99) < 5)
            rx_quiet = !rx_quiet;
         gap = rx_quiet ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : byte_source
      int small_bytes;
      int len;
      small_bytes = 0;
      clear_scanner();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++)
         offer_byte(directed_rows[i].ch, directed_rows[i].eob, directed_rows[i].typed,
                    directed_rows[i].first, directed_rows[i].second);

      while (small_bytes < SMALL_BYTES) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 30);
         for (int j = 0; j < len; j++)
            offer_byte(pick_char(), j == len - 1);
         small_bytes += len;
         if ($urandom_range(0, 99) < 15)
            tx_quiet = !tx_quiet;
      end

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d buffers, %0d of them run past the size limit.",
               bytes_accepted, buffers_closed, overflow_buffers);
      $display("Checked %0d result items, %0d words and %0d lines.",
               results_checked, results_checked - lines_checked, lines_checked);
      if (mismatches == 0)
         $display("script_line_word_tokenizer_tb passed");
      else
         $display("script_line_word_tokenizer_tb failed");
      $finish;
   end

endmodule
